/* sv/ghst_pkg.sv */
// Shared types, constants and codes for the generational handle slot table.
`default_nettype none

package ghst_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 256;
    localparam int ARRAY_DEPTH = 256;
    localparam int SLOT_LIMIT  = (SLOT_COUNT < ARRAY_DEPTH) ? SLOT_COUNT : ARRAY_DEPTH;

    localparam int IDX_W  = 8;
    localparam int GEN_W  = 8;
    localparam int PAY_W  = 32;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 3;
    localparam int MODE_W = 2;
    localparam int ENTRY_W = GEN_W + PAY_W;

    localparam logic [IDX_W:0] SLOT_LIMIT_L = (IDX_W + 1)'(SLOT_LIMIT);

    // Free-slot scan: one window of active flags per cycle
    localparam int SCAN_W      = 16;
    localparam int SCAN_GROUPS = ARRAY_DEPTH / SCAN_W;
    localparam int GROUP_W     = $clog2(SCAN_GROUPS);
    localparam int SEL_W       = $clog2(SCAN_W);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_STALE   = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_gen;
        logic [PAY_W-1:0]  payload;
        logic              name_present;
        logic              factory_present;
    } ghst_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  out_index;
        logic [GEN_W-1:0]  out_gen;
        logic [PAY_W-1:0]  out_payload;
        logic [CNT_W-1:0]  live_count;
    } ghst_out_t;

    typedef struct packed {
        logic start;
        logic step;
    } ghst_scan_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic             last;
        logic [IDX_W-1:0] slot;
    } ghst_scan_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EXEC,
        S_RESP
    } ghst_state_t;

endpackage

`default_nettype wire

/* sv/generational_handle_slot_table.sv */
// Top level of the generational handle slot table.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation word:
//   register, lookup, unregister or clear-all. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result word per request.
//   Handles pair an 8-bit slot index with an 8-bit generation; slot 0 is
//   reserved.
// Sequencing:
//   One request at a time; req_ready is high only while the sequencer idles.
//   Lookup and unregister pass through RAM read, compare/update and result
//   hand-off. Register first scans 16-slot windows, from 1 to 16 of them,
//   until it reaches the lowest inactive slot, then goes the same way; a
//   full table scans all 16 windows. Bad arguments, bad handle indexes and
//   clear-all go straight to the result hand-off.
// Reset:
//   All slots inactive, all generations zero (per-slot written flags), live
//   count zero. No clearing pass is needed; the block is ready right away.
// Stalls:
//   Results sit in an output register; a new request can be accepted while
//   it waits. A later result waits in the sequencer until that register frees.
`default_nettype none

module generational_handle_slot_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ghst_pkg::ghst_in_t    req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ghst_pkg::ghst_out_t   rsp
);
    import ghst_pkg::*;

    ghst_state_t state_reg;
    ghst_state_t state_next;

    // Request and working registers
    ghst_in_t               req_reg;
    ghst_in_t               req_next;
    logic [IDX_W-1:0]       slot_reg;
    logic [IDX_W-1:0]       slot_next;
    ghst_out_t              res_reg;
    ghst_out_t              res_next;

    // Per-slot flags and live count
    logic [ARRAY_DEPTH-1:0] active_reg;
    logic [ARRAY_DEPTH-1:0] active_next;
    logic [ARRAY_DEPTH-1:0] written_reg;
    logic [ARRAY_DEPTH-1:0] written_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Output register
    ghst_out_t              rsp_reg;
    ghst_out_t              rsp_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;

    // Control strobes
    logic                   accept;
    logic                   rsp_load;
    ghst_scan_ctrl_t        scan_ctrl;
    ghst_scan_stat_t        scan_stat;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    // Entry decode
    logic [GEN_W-1:0]       gen_cur;
    logic [GEN_W-1:0]       gen_inc;
    logic [GEN_W-1:0]       gen_new;
    logic                   handle_match;
    logic                   req_ok;
    logic                   idx_zero;
    logic                   idx_range;

    assign accept   = req_valid && req_ready;
    assign rsp_load = (state_reg == S_RESP) && (!rsp_valid_reg || rsp_ready);

    // Early checks on the incoming word
    assign req_ok    = req.name_present && req.factory_present;
    assign idx_zero  = (req.handle_index == '0);
    assign idx_range = ({1'b0, req.handle_index} >= SLOT_LIMIT_L);

    // Stored generation; an entry never written reads as generation 0.
    assign gen_cur      = written_reg[slot_reg] ? ram_rdata[ENTRY_W-1 -: GEN_W] : '0;
    assign gen_inc      = gen_cur + GEN_W'(1);
    assign gen_new      = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
    assign handle_match = active_reg[slot_reg] && (gen_cur == req_reg.handle_gen);
    assign ram_wdata    = {gen_new, req_reg.payload};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.mode)
                        MODE_REGISTER:
                            state_next = req_ok ? S_SCAN : S_RESP;
                        MODE_LOOKUP, MODE_UNREGISTER:
                            state_next = (idx_zero || idx_range) ? S_RESP : S_READ;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    state_next = S_READ;
                end
                else if (scan_stat.last)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
                state_next = S_EXEC;
            S_EXEC:
                state_next = S_RESP;
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_ready       = (state_reg == S_IDLE);
        scan_ctrl.start = (state_reg == S_IDLE);
        scan_ctrl.step  = (state_reg == S_SCAN);
        ram_we          = (state_reg == S_EXEC) && (req_reg.mode == MODE_REGISTER);
    end

    // Datapath
    always_comb
    begin
        req_next       = req_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        active_next    = active_reg;
        written_next   = written_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next             = req;
                    slot_next            = req.handle_index;
                    res_next.status      = ST_OK;
                    res_next.out_index   = '0;
                    res_next.out_gen     = '0;
                    res_next.out_payload = '0;
                    res_next.live_count  = count_reg;
                    case (req.mode)
                        MODE_REGISTER:
                        begin
                            if (!req_ok)
                            begin
                                res_next.status = ST_BAD_ARG;
                            end
                        end
                        MODE_LOOKUP, MODE_UNREGISTER:
                        begin
                            if (idx_zero)
                            begin
                                res_next.status = ST_INVALID;
                            end
                            else if (idx_range)
                            begin
                                res_next.status = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            // clear-all: generations survive
                            active_next         = '0;
                            count_next          = '0;
                            res_next.live_count = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    slot_next = scan_stat.slot;
                end
                else if (scan_stat.last)
                begin
                    res_next.status = ST_FULL;
                end
            end
            S_EXEC:
            begin
                if (req_reg.mode == MODE_REGISTER)
                begin
                    active_next[slot_reg]  = 1'b1;
                    written_next[slot_reg] = 1'b1;
                    count_next             = count_reg + CNT_W'(1);
                    res_next.status        = ST_OK;
                    res_next.out_index     = slot_reg;
                    res_next.out_gen       = gen_new;
                    res_next.live_count    = count_reg + CNT_W'(1);
                end
                else if (!handle_match)
                begin
                    res_next.status = ST_STALE;
                end
                else if (req_reg.mode == MODE_LOOKUP)
                begin
                    res_next.out_payload = ram_rdata[PAY_W-1:0];
                end
                else
                begin
                    // unregister: count saturates at zero
                    active_next[slot_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    res_next.live_count = (count_reg != '0) ? count_reg - CNT_W'(1) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            written_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            written_reg   <= written_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    ghst_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .active (active_reg),
        .stat   (scan_stat)
    );

    // Generation and payload of each slot, one word per slot
    ghst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ARRAY_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* sv/ghst_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module ghst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ghst_scan.sv */
// Iterative free-slot finder: checks one window of active flags per cycle.
`default_nettype none

module ghst_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ghst_pkg::ghst_scan_ctrl_t           ctrl,
    input  logic [ghst_pkg::ARRAY_DEPTH-1:0]    active,
    output ghst_pkg::ghst_scan_stat_t           stat
);
    import ghst_pkg::*;

    logic [GROUP_W-1:0] group_reg;
    logic [GROUP_W-1:0] group_next;
    logic [SCAN_W-1:0]  window;
    logic [SCAN_W-1:0]  free;
    logic [SEL_W-1:0]   sel;
    logic               hit;

    always_comb
    begin
        group_next = group_reg;
        if (ctrl.start)
        begin
            group_next = '0;
        end
        else if (ctrl.step)
        begin
            group_next = group_reg + GROUP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
        end
        else
        begin
            group_reg <= group_next;
        end
    end

    assign window = active[group_reg * SCAN_W +: SCAN_W];

    // Slot 0 and slots past the limit never count as free.
    always_comb
    begin
        for (int j = 0; j < SCAN_W; j++)
        begin
            free[j] = !window[j]
                && ({group_reg, SEL_W'(j)} != '0)
                && ({1'b0, group_reg, SEL_W'(j)} < SLOT_LIMIT_L);
        end
    end

    // Lowest free bit in the window.
    always_comb
    begin
        hit = 1'b0;
        sel = '0;
        for (int j = SCAN_W - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                hit = 1'b1;
                sel = SEL_W'(j);
            end
        end
    end

    assign stat.hit  = hit;
    assign stat.last = (group_reg == GROUP_W'(SCAN_GROUPS - 1));
    assign stat.slot = {group_reg, sel};

endmodule

`default_nettype wire

/* test/generational_handle_slot_table_tb.sv */
// Testbench for the generational handle slot table: scripted and random words checked against a behavioral table.
`timescale 1ns / 1ps

module generational_handle_slot_table_tb;

    import ghst_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int DIRECTED_ROWS  = 23;
    localparam int RANDOM_WORDS   = 250;
    localparam int WRAP_PAIRS     = 260;   // more than one full turn of an 8-bit generation

    typedef struct {
        ghst_in_t  word;
        bit        known;   // rsp below is typed in by hand
        ghst_out_t rsp;
    } script_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    ghst_in_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    ghst_out_t rsp;

    // Shadow copy of the table
    bit               slot_live [SLOT_LIMIT] = '{default: 1'b0};
    logic [GEN_W-1:0] slot_gen  [SLOT_LIMIT] = '{default: '0};
    logic [PAY_W-1:0] slot_word [SLOT_LIMIT] = '{default: '0};
    logic [CNT_W-1:0] live_total = '0;

    ghst_out_t   pending_rsp [$];
    script_row_t script [DIRECTED_ROWS];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    int          stall_mode   = 0;
    int          stall_left   = 0;

    generational_handle_slot_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #CLK_HALF clk = ~clk;

    function automatic ghst_in_t op_word(input logic [MODE_W-1:0] mode,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [GEN_W-1:0] gen,
                                         input logic [PAY_W-1:0] pay,
                                         input logic nm, input logic fa);
        ghst_in_t w;
        w.mode            = mode;
        w.handle_index    = idx;
        w.handle_gen      = gen;
        w.payload         = pay;
        w.name_present    = nm;
        w.factory_present = fa;
        return w;
    endfunction

    function automatic ghst_out_t rsp_word(input logic [STAT_W-1:0] st,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [GEN_W-1:0] gen,
                                           input logic [PAY_W-1:0] pay,
                                           input logic [CNT_W-1:0] cnt);
        ghst_out_t o;
        o.status      = st;
        o.out_index   = idx;
        o.out_gen     = gen;
        o.out_payload = pay;
        o.live_count  = cnt;
        return o;
    endfunction

    function automatic logic [STAT_W-1:0] handle_status(input ghst_in_t w);
        if (w.handle_index == '0)
            return ST_INVALID;
        if (int'(w.handle_index) >= SLOT_LIMIT)
            return ST_RANGE;
        if (!slot_live[w.handle_index] || slot_gen[w.handle_index] != w.handle_gen)
            return ST_STALE;
        return ST_OK;
    endfunction

    // Carries out one operation on the shadow table and returns its result word.
    function automatic ghst_out_t apply_table_op(input ghst_in_t w);
        ghst_out_t        o;
        int               free_slot;
        logic [GEN_W-1:0] g;
        o = '0;
        o.status = ST_OK;
        case (w.mode)
            MODE_REGISTER:
            begin
                // missing name or factory wins over a full table
                if (!w.name_present || !w.factory_present)
                    o.status = ST_BAD_ARG;
                else
                begin
                    free_slot = 0;
                    for (int i = SLOT_LIMIT - 1; i >= 1; i--)
                        if (!slot_live[i])
                            free_slot = i;
                    if (free_slot == 0)
                        o.status = ST_FULL;
                    else
                    begin
                        g = slot_gen[free_slot] + 1'b1;
                        if (g == '0)
                            g = 1;    // generation 0 is never handed out
                        slot_gen[free_slot]  = g;
                        slot_word[free_slot] = w.payload;
                        slot_live[free_slot] = 1'b1;
                        live_total           = live_total + 1'b1;
                        o.out_index          = IDX_W'(free_slot);
                        o.out_gen            = g;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                o.status = handle_status(w);
                if (o.status == ST_OK)
                    o.out_payload = slot_word[w.handle_index];
            end
            MODE_UNREGISTER:
            begin
                o.status = handle_status(w);
                if (o.status == ST_OK)
                begin
                    slot_live[w.handle_index] = 1'b0;
                    if (live_total != '0)
                        live_total = live_total - 1'b1;
                end
            end
            default:
            begin
                // clear-all keeps every generation
                slot_live  = '{default: 1'b0};
                live_total = '0;
            end
        endcase
        o.live_count = live_total;
        return o;
    endfunction

    function automatic ghst_in_t register_op();
        return op_word(MODE_REGISTER, IDX_W'($urandom), GEN_W'($urandom), $urandom,
                       1'b1, 1'b1);
    endfunction

    // Lookup or unregister: mostly a live handle, some with a wrong generation,
    // the rest fully random.
    function automatic ghst_in_t handle_op(input logic [MODE_W-1:0] mode);
        ghst_in_t w;
        int       start;
        int       idx;
        int       r;
        w = op_word(mode, IDX_W'($urandom), GEN_W'($urandom), $urandom,
                    1'($urandom), 1'($urandom));
        r = $urandom_range(0, 9);
        if (r < 9 && live_total != '0)
        begin
            start = $urandom_range(1, SLOT_LIMIT - 1);
            idx   = start;
            for (int k = 0; k < SLOT_LIMIT - 1; k++)
            begin
                idx = (start - 1 + k) % (SLOT_LIMIT - 1) + 1;
                if (slot_live[idx])
                    break;
            end
            w.handle_index = IDX_W'(idx);
            w.handle_gen   = (r == 8) ? GEN_W'(slot_gen[idx] + $urandom_range(1, 255))
                                      : slot_gen[idx];
        end
        return w;
    endfunction

    function automatic ghst_in_t random_op();
        ghst_in_t w;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 38)
        begin
            w = register_op();
            if ($urandom_range(0, 9) == 0)
            begin
                w.name_present    = 1'($urandom);
                w.factory_present = 1'($urandom);
            end
        end
        else if (r < 68)
            w = handle_op(MODE_LOOKUP);
        else if (r < 94)
            w = handle_op(MODE_UNREGISTER);
        else if (r < 96)
            w = op_word(MODE_CLEAR, IDX_W'($urandom), GEN_W'($urandom), $urandom,
                        1'($urandom), 1'($urandom));
        else
            w = op_word(MODE_W'($urandom), IDX_W'($urandom), GEN_W'($urandom), $urandom,
                        1'($urandom), 1'($urandom));
        return w;
    endfunction

    // Drives one request word in sender bursts, then records its expected result.
    task automatic send_op(input ghst_in_t w, input bit known, input ghst_out_t known_rsp);
        ghst_out_t predicted;
        int        gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_table_op(w);
        pending_rsp.push_back(known ? known_rsp : predicted);
        burst_left--;
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [PAY_W-1:0] want,
                               input logic [PAY_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    // Receiver: switches between always ready, light stalls and heavy stalls.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        ghst_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result word with nothing pending: %p", rsp);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", PAY_W'(want.status), PAY_W'(rsp.status));
                check_field("out_index", PAY_W'(want.out_index), PAY_W'(rsp.out_index));
                check_field("out_gen", PAY_W'(want.out_gen), PAY_W'(rsp.out_gen));
                check_field("out_payload", want.out_payload, rsp.out_payload);
                check_field("live_count", PAY_W'(want.live_count), PAY_W'(rsp.live_count));
            end
        end
    end

    // Watchdog: too long with no word moving on either side.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        ghst_in_t         w;
        logic [GEN_W-1:0] g;

        script = '{
            // rejected registers, empty table
            '{op_word(MODE_REGISTER, 8'h00, 8'h00, 32'h0, 1'b0, 1'b1), 1'b1,
              rsp_word(ST_BAD_ARG, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_REGISTER, 8'h00, 8'h00, 32'h0, 1'b1, 1'b0), 1'b1,
              rsp_word(ST_BAD_ARG, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_REGISTER, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_BAD_ARG, 8'd0, 8'd0, 32'h0, 8'd0)},
            // index zero, inactive slots
            '{op_word(MODE_LOOKUP, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_INVALID, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_UNREGISTER, 8'h00, 8'hFF, 32'h0, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_INVALID, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_LOOKUP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_UNREGISTER, 8'h01, 8'h00, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd0)},
            // first registers, handle fields ignored
            '{op_word(MODE_REGISTER, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_OK, 8'd1, 8'd1, 32'h0, 8'd1)},
            '{op_word(MODE_REGISTER, 8'h00, 8'h00, 32'h0, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_OK, 8'd2, 8'd1, 32'h0, 8'd2)},
            '{op_word(MODE_LOOKUP, 8'h01, 8'h01, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_OK, 8'd0, 8'd0, 32'hFFFF_FFFF, 8'd2)},
            // generation zero never matches
            '{op_word(MODE_LOOKUP, 8'h01, 8'h00, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd2)},
            '{op_word(MODE_LOOKUP, 8'h02, 8'h02, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd2)},
            '{op_word(MODE_UNREGISTER, 8'h01, 8'h01, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_OK, 8'd0, 8'd0, 32'h0, 8'd1)},
            // old handle goes stale, double unregister refused
            '{op_word(MODE_LOOKUP, 8'h01, 8'h01, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd1)},
            '{op_word(MODE_UNREGISTER, 8'h01, 8'h01, 32'h0, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd1)},
            // freed slot comes back with the next generation
            '{op_word(MODE_REGISTER, 8'h00, 8'h00, 32'hA5A5_5A5A, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_OK, 8'd1, 8'd2, 32'h0, 8'd2)},
            '{op_word(MODE_LOOKUP, 8'h02, 8'h01, 32'h0, 1'b0, 1'b1), 1'b0, '0},
            '{op_word(MODE_LOOKUP, 8'h01, 8'h02, 32'h0, 1'b1, 1'b0), 1'b0, '0},
            // clear-all, then everything old is stale
            '{op_word(MODE_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b1,
              rsp_word(ST_OK, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_LOOKUP, 8'h01, 8'h02, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_UNREGISTER, 8'h02, 8'h01, 32'h0, 1'b0, 1'b0), 1'b1,
              rsp_word(ST_STALE, 8'd0, 8'd0, 32'h0, 8'd0)},
            '{op_word(MODE_REGISTER, 8'h5A, 8'hA5, 32'h1234_5678, 1'b1, 1'b1), 1'b0, '0},
            '{op_word(MODE_REGISTER, 8'hA5, 8'h5A, 32'h8000_0001, 1'b1, 1'b1), 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
            send_op(script[n].word, script[n].known, script[n].rsp);
        drain_results();

        // General churn over live and stale handles
        for (int n = 0; n < RANDOM_WORDS; n++)
            send_op(random_op(), 1'b0, '0);
        drain_results();

        // Fill the table, hit the full case, then punch holes and refill them
        send_op(op_word(MODE_CLEAR, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0), 1'b0, '0);
        while (int'(live_total) < SLOT_LIMIT - 1)
        begin
            if ($urandom_range(0, 5) == 0)
                send_op(handle_op(MODE_LOOKUP), 1'b0, '0);
            else
                send_op(register_op(), 1'b0, '0);
        end
        repeat (4) send_op(register_op(), 1'b0, '0);
        w = register_op();
        w.name_present = 1'b0;    // bad argument outranks full
        send_op(w, 1'b0, '0);
        repeat (3)
        begin
            w = handle_op(MODE_UNREGISTER);
            w.handle_gen = slot_gen[w.handle_index];
            send_op(w, 1'b0, '0);
        end
        repeat (4) send_op(register_op(), 1'b0, '0);
        drain_results();

        // Cycle slot 1 through a generation wrap
        send_op(op_word(MODE_CLEAR, 8'hFF, 8'h00, 32'h0, 1'b1, 1'b0), 1'b0, '0);
        for (int p = 0; p < WRAP_PAIRS; p++)
        begin
            send_op(register_op(), 1'b0, '0);
            g = slot_gen[1];
            if (p % 8 == 0)
                send_op(op_word(MODE_LOOKUP, 8'h01, g, $urandom, 1'($urandom), 1'($urandom)),
                        1'b0, '0);
            if (p % 16 == 1)
                send_op(op_word(MODE_LOOKUP, 8'h01, g - 1'b1, $urandom, 1'b0, 1'b0),
                        1'b0, '0);
            send_op(op_word(MODE_UNREGISTER, 8'h01, g, $urandom, 1'($urandom), 1'($urandom)),
                    1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
